[src/ole_pkg.sv]
`default_nettype none
package ole_pkg;
    localparam int DefCapacity = 16;
    localparam int ValueW = 32;
    localparam int PosW = 16;

    typedef enum logic [2:0] {
        FN_INSERT = 3'd0,
        FN_APPEND = 3'd1,
        FN_DEL_POS = 3'd2,
        FN_DEL_VAL = 3'd3,
        FN_POP = 3'd4,
        FN_READ = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_EMPTY = 3'd1,
        ST_BOUNDS = 3'd2,
        ST_NOMATCH = 3'd3,
        ST_FULL = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic ins;
        logic del;
        logic scan;
        logic wr;
    } cell_cmd_t;
endpackage
`default_nettype wire

[src/ole_cell.sv]
`default_nettype none
module ole_cell
    import ole_pkg::*;
#(
    parameter int IDX_W = 4
)
(
    input  wire logic              clk,
    input  wire logic [IDX_W-1:0]  my_idx,
    input  wire cell_cmd_t         cmd,
    input  wire logic [IDX_W:0]    pos,
    input  wire logic [ValueW-1:0] value,
    input  wire logic [ValueW-1:0] left_data,
    input  wire logic [ValueW-1:0] right_data,
    output logic [ValueW-1:0]      data
);
    logic [ValueW-1:0] data_reg;
    logic [ValueW-1:0] data_next;
    logic              at_pos;
    logic              past_pos;

    assign at_pos = {1'b0, my_idx} == pos;
    assign past_pos = {1'b0, my_idx} > pos;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (at_pos)
                data_next = value;
            else if (past_pos)
                data_next = left_data;
        end
        else if (cmd.del)
        begin
            if (at_pos || past_pos)
                data_next = right_data;
        end
        else if (cmd.scan)
        begin
            // During a walk the chain moves toward cell 0 and a kept entry is laid back in.
            if (cmd.wr && at_pos)
                data_next = value;
            else
                data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
endmodule
`default_nettype wire

[src/ordered_list_engine.sv]
// Insert, append, delete at position and pop: the result shows in the cycle after the
// accepting edge and busy stays low. A walk (read out or delete by value on a nonempty
// list) moves the cell chain one entry per cycle and registers its results; busy is high
// through the walk and, in delete by value, also in a final done state. One request is
// taken at a time. Reset clears the count and the controller; stored values stay
// undefined. No stall.
`default_nettype none
module ordered_list_engine
    import ole_pkg::*;
#(
    parameter int CAPACITY = DefCapacity
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [2:0]        func,
    input  wire logic [ValueW-1:0] value,
    input  wire logic [PosW-1:0]   position,
    output logic                   out_valid,
    output logic [2:0]             status,
    output logic [ValueW-1:0]      item_value,
    output logic [PosW-1:0]        item_index,
    output logic                   last
);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = IDX_W + 1;

    logic [ValueW-1:0] cell_data [CAPACITY];
    cell_cmd_t         cmd;
    logic [CNT_W-1:0]  cmd_pos;
    logic [ValueW-1:0] cmd_value;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic [CNT_W-1:0]  kept_reg, kept_next;
    logic [2:0]        func_reg, func_next;
    logic [ValueW-1:0] value_reg, value_next;
    logic              pend_reg, pend_next;
    logic [PosW-1:0]   pend_idx_reg, pend_idx_next;

    logic              ov_reg, ov_next;
    status_t           st_reg, st_next;
    logic [ValueW-1:0] iv_reg, iv_next;
    logic [PosW-1:0]   ii_reg, ii_next;
    logic              last_reg, last_next;

    logic [PosW-1:0]   cnt_ext;
    logic              accept;
    logic              walk_req;
    logic              scan_end;
    logic [CNT_W-1:0]  wr_pos;
    logic [ValueW-1:0] head;
    logic [ValueW-1:0] tail_value;

    assign busy = state_reg != S_IDLE;
    assign accept = start && !busy;
    assign walk_req = func == FN_DEL_VAL || func == FN_READ;
    assign cnt_ext = {{(PosW-CNT_W){1'b0}}, count_reg};
    assign scan_end = scan_reg == count_reg - CNT_W'(1);
    assign wr_pos = count_reg - CNT_W'(1) - scan_reg + kept_reg;
    assign head = cell_data[0];

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic [ValueW-1:0] left_d;
        logic [ValueW-1:0] right_d;

        if (k == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_inner_left
            assign left_d = cell_data[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_final
            assign right_d = '0;
        end
        else
        begin : g_inner_right
            assign right_d = cell_data[k+1];
        end

        ole_cell #(
            .IDX_W(IDX_W)
        ) u_cell (
            .clk(clk),
            .my_idx(IDX_W'(k)),
            .cmd(cmd),
            .pos(cmd_pos),
            .value(cmd_value),
            .left_data(left_d),
            .right_data(right_d),
            .data(cell_data[k])
        );
    end

    always_comb
    begin
        tail_value = '0;
        for (int k = 0; k < CAPACITY; k++)
            if (CNT_W'(k) == count_reg - CNT_W'(1))
                tail_value = cell_data[k];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept && walk_req && count_reg != '0)
                    state_next = S_SCAN;
            S_SCAN:
                if (scan_end)
                    state_next = (func_reg == FN_DEL_VAL) ? S_DONE : S_IDLE;
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd_pos = '0;
        cmd_value = value;
        count_next = count_reg;
        scan_next = scan_reg;
        kept_next = kept_reg;
        func_next = func_reg;
        value_next = value_reg;
        pend_next = pend_reg;
        pend_idx_next = pend_idx_reg;
        ov_next = 1'b0;
        st_next = ST_OK;
        iv_next = '0;
        ii_next = '0;
        last_next = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next = func;
                    value_next = value;
                    scan_next = '0;
                    kept_next = '0;
                    pend_next = 1'b0;
                    case (func)
                        FN_INSERT, FN_APPEND:
                        begin
                            ov_next = 1'b1;
                            if (func == FN_INSERT && position > cnt_ext)
                                st_next = ST_BOUNDS;
                            else if (count_reg == CNT_W'(CAPACITY))
                                st_next = ST_FULL;
                            else
                            begin
                                cmd.ins = 1'b1;
                                cmd_pos = (func == FN_APPEND) ? count_reg : CNT_W'(position);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        FN_DEL_POS:
                        begin
                            ov_next = 1'b1;
                            if (count_reg == '0)
                                st_next = ST_EMPTY;
                            else if (position >= cnt_ext)
                                st_next = ST_BOUNDS;
                            else
                            begin
                                cmd.del = 1'b1;
                                cmd_pos = CNT_W'(position);
                                ii_next = position;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        FN_POP:
                        begin
                            ov_next = 1'b1;
                            if (count_reg == '0)
                                st_next = ST_EMPTY;
                            else
                            begin
                                iv_next = tail_value;
                                ii_next = PosW'(count_reg - CNT_W'(1));
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        FN_DEL_VAL, FN_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                ov_next = 1'b1;
                                st_next = ST_EMPTY;
                            end
                        end
                        default:
                            ;
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                cmd_pos = wr_pos;
                cmd_value = head;
                scan_next = scan_reg + CNT_W'(1);
                if (func_reg == FN_READ)
                begin
                    cmd.wr = 1'b1;
                    kept_next = kept_reg + CNT_W'(1);
                    ov_next = 1'b1;
                    iv_next = head;
                    ii_next = PosW'(scan_reg);
                    last_next = scan_end;
                end
                else if (head == value_reg)
                begin
                    // A match is held back until the next one shows whether it is the final.
                    pend_next = 1'b1;
                    pend_idx_next = PosW'(scan_reg);
                    ov_next = pend_reg;
                    ii_next = pend_idx_reg;
                    last_next = 1'b0;
                end
                else
                begin
                    cmd.wr = 1'b1;
                    kept_next = kept_reg + CNT_W'(1);
                end
            end
            S_DONE:
            begin
                count_next = kept_reg;
                ov_next = 1'b1;
                if (pend_reg)
                    ii_next = pend_idx_reg;
                else
                    st_next = ST_NOMATCH;
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        kept_reg <= kept_next;
        func_reg <= func_next;
        value_reg <= value_next;
        pend_reg <= pend_next;
        pend_idx_reg <= pend_idx_next;
        st_reg <= st_next;
        iv_reg <= iv_next;
        ii_reg <= ii_next;
        last_reg <= last_next;
    end

    assign out_valid = ov_reg;
    assign status = st_reg;
    assign item_value = iv_reg;
    assign item_index = ii_reg;
    assign last = last_reg;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY)) else $error("count over capacity");
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> scan_reg < count_reg) else $error("walk past the count");
    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |=> state_reg == S_IDLE) else $error("done not followed by idle");
    a_last_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |=> out_valid && last) else $error("missing final result");
`endif
endmodule
`default_nettype wire

[tb/tb_ordered_list_engine.sv]
`timescale 1ns / 1ps

module tb_ordered_list_engine
    import ole_pkg::*;
;

    localparam int Cap = DefCapacity;

    typedef struct {
        logic [2:0]        status;
        logic [ValueW-1:0] item_value;
        logic [PosW-1:0]   item_index;
        logic              last;
    } list_result_t;

    class list_scoreboard;
        logic [ValueW-1:0] entries[Cap];
        int                count;
        list_result_t      pending[$];
        int                errors;
        int                results_seen;
        int                requests_seen;

        function new();
            count = 0;
            errors = 0;
            results_seen = 0;
            requests_seen = 0;
        endfunction

        function void push(logic [2:0] st, logic [ValueW-1:0] v, logic [PosW-1:0] ix,
                           logic lst);
            list_result_t r;
            r.status = st;
            r.item_value = v;
            r.item_index = ix;
            r.last = lst;
            pending.push_back(r);
        endfunction

        function void note_request(logic [2:0] fn, logic [ValueW-1:0] v, logic [PosW-1:0] p);
            int keep;
            int hits;
            requests_seen++;
            case (fn)
                FN_INSERT:
                begin
                    if (p > count) push(ST_BOUNDS, '0, '0, 1'b1);
                    else if (count >= Cap) push(ST_FULL, '0, '0, 1'b1);
                    else
                    begin
                        for (int i = count; i > p; i--) entries[i] = entries[i-1];
                        entries[p] = v;
                        count++;
                        push(ST_OK, '0, '0, 1'b1);
                    end
                end
                FN_APPEND:
                begin
                    if (count >= Cap) push(ST_FULL, '0, '0, 1'b1);
                    else
                    begin
                        entries[count] = v;
                        count++;
                        push(ST_OK, '0, '0, 1'b1);
                    end
                end
                FN_DEL_POS:
                begin
                    if (count == 0) push(ST_EMPTY, '0, '0, 1'b1);
                    else if (p >= count) push(ST_BOUNDS, '0, '0, 1'b1);
                    else
                    begin
                        for (int i = p; i + 1 < count; i++) entries[i] = entries[i+1];
                        count--;
                        push(ST_OK, '0, p, 1'b1);
                    end
                end
                FN_DEL_VAL:
                begin
                    if (count == 0) push(ST_EMPTY, '0, '0, 1'b1);
                    else
                    begin
                        keep = 0;
                        hits = 0;
                        for (int i = 0; i < count; i++)
                        begin
                            if (entries[i] == v)
                            begin
                                push(ST_OK, '0, PosW'(i), 1'b0);
                                hits++;
                            end
                            else
                            begin
                                entries[keep] = entries[i];
                                keep++;
                            end
                        end
                        count = keep;
                        if (hits == 0) push(ST_NOMATCH, '0, '0, 1'b1);
                        else pending[$].last = 1'b1;
                    end
                end
                FN_POP:
                begin
                    if (count == 0) push(ST_EMPTY, '0, '0, 1'b1);
                    else
                    begin
                        count--;
                        push(ST_OK, entries[count], PosW'(count), 1'b1);
                    end
                end
                FN_READ:
                begin
                    if (count == 0) push(ST_EMPTY, '0, '0, 1'b1);
                    else
                        for (int i = 0; i < count; i++)
                            push(ST_OK, entries[i], PosW'(i), i + 1 == count);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [2:0] st, logic [ValueW-1:0] v, logic [PosW-1:0] ix,
                                   logic lst);
            list_result_t e;
            results_seen++;
            if (pending.size() == 0)
            begin
                $error("unexpected result: status %0d value %0h index %0d", st, v, ix);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, st);
                errors++;
            end
            if (v !== e.item_value)
            begin
                $error("item_value: expected %0h, actual %0h", e.item_value, v);
                errors++;
            end
            if (ix !== e.item_index)
            begin
                $error("item_index: expected %0d, actual %0d", e.item_index, ix);
                errors++;
            end
            if (lst !== e.last)
            begin
                $error("last: expected %0b, actual %0b", e.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [2:0]        func;
    logic [ValueW-1:0] value;
    logic [PosW-1:0]   position;
    logic              out_valid;
    logic [2:0]        status;
    logic [ValueW-1:0] item_value;
    logic [PosW-1:0]   item_index;
    logic              last;

    list_scoreboard board;
    bit             quiet_tail;
    logic [ValueW-1:0] recent_vals[$];

    ordered_list_engine dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .value(value),
        .position(position),
        .out_valid(out_valid),
        .status(status),
        .item_value(item_value),
        .item_index(item_index),
        .last(last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            board.note_request(func, value, position);
        if (rst_n && out_valid)
            board.check_result(status, item_value, item_index, last);
    end

    task automatic send_request(logic [2:0] fn, logic [ValueW-1:0] v, logic [PosW-1:0] p);
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            func <= 3'($urandom);
            value <= $urandom;
            position <= PosW'($urandom);
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        start <= 1'b1;
        func <= fn;
        value <= v;
        position <= p;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [ValueW-1:0] pick_value();
        if (recent_vals.size() > 0 && $urandom_range(0, 2) == 0)
            return recent_vals[$urandom_range(0, recent_vals.size() - 1)];
        pick_value = ($urandom_range(0, 1) == 0) ? ValueW'($urandom_range(0, 3)) : $urandom;
        recent_vals.push_back(pick_value);
        if (recent_vals.size() > 6) void'(recent_vals.pop_front());
    endfunction

    function automatic logic [PosW-1:0] pick_position();
        case ($urandom_range(0, 9))
            0: return PosW'($urandom);
            1: return PosW'(board.count);
            2: return PosW'(board.count + 1);
            default: return PosW'($urandom_range(0, board.count));
        endcase
    endfunction

    task automatic random_request();
        int r;
        logic [2:0] fn;
        r = $urandom_range(0, 99);
        if (r < 22) fn = FN_INSERT;
        else if (r < 44) fn = FN_APPEND;
        else if (r < 58) fn = FN_DEL_POS;
        else if (r < 72) fn = FN_DEL_VAL;
        else if (r < 84) fn = FN_POP;
        else if (r < 96) fn = FN_READ;
        else fn = 3'($urandom_range(6, 7));
        send_request(fn, pick_value(), pick_position());
    endtask

    initial
    begin
        board = new();
        quiet_tail = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        func = '0;
        value = '0;
        position = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_request(FN_READ, '0, '0);
        send_request(FN_POP, '0, '0);
        send_request(FN_DEL_POS, '0, '0);
        send_request(FN_DEL_VAL, 32'h7, '0);
        send_request(FN_INSERT, 32'h1, 16'd1);
        send_request(FN_INSERT, 32'h8000_0000, 16'd0);
        send_request(FN_APPEND, 32'h7FFF_FFFF, '0);
        send_request(FN_INSERT, 32'hFFFF_FFFF, 16'd1);
        send_request(FN_DEL_POS, '0, 16'hFFFF);
        send_request(FN_INSERT, '0, 16'hFFFF);
        for (int i = 0; i < Cap - 3; i++) send_request(FN_APPEND, 32'h5, '0);
        send_request(FN_APPEND, 32'h1, '0);
        send_request(FN_INSERT, 32'h1, 16'd0);
        send_request(FN_INSERT, 32'h1, 16'd17);
        send_request(FN_READ, '0, '0);
        send_request(FN_DEL_VAL, 32'h9, '0);
        send_request(3'd6, '0, '0);
        send_request(3'd7, '1, '1);
        send_request(FN_DEL_VAL, 32'h5, '0);
        send_request(FN_POP, '0, '0);
        send_request(FN_DEL_POS, '0, 16'd1);

        for (int n = 0; n < 130; n++)
        begin
            if (n == 100) quiet_tail = 1'b1;
            random_request();
        end
        start <= 1'b0;

        for (int w = 0; w < 1000 && board.pending.size() > 0; w++) @(posedge clk);
        repeat (Cap + 10) @(posedge clk);
        $display("Covered %0d requests and %0d results over all six operations,",
                 board.requests_seen, board.results_seen);
        $display("including empty, full, out-of-range and unmatched cases.");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("status: fail");
        $finish;
    end
endmodule

[files.f]
src/ole_pkg.sv
src/ole_cell.sv
src/ordered_list_engine.sv
tb/tb_ordered_list_engine.sv
